/* sv/ldbr_pkg.sv */
// Shared types, opcodes and level/duty helpers for the LED dimmer button ramp.
// No dependencies; imported by every module of the block.
package ldbr_pkg;

	localparam int PctW  = 7;
	localparam int HoldW = 16;
	localparam int OpW   = 3;
	localparam int DutyW = 8;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	localparam logic [OpW-1:0] OP_TICK   = 3'd0;
	localparam logic [OpW-1:0] OP_CLICK  = 3'd1;
	localparam logic [OpW-1:0] OP_DOUBLE = 3'd2;
	localparam logic [OpW-1:0] OP_TRIPLE = 3'd3;
	localparam logic [OpW-1:0] OP_LONG   = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_INITIAL_LEVEL  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_HOLD_THRESHOLD = 2'd1;

	localparam logic [PctW-1:0] PCT_FULL = 7'd100;

	typedef struct packed {
		logic [HoldW-1:0] hold_time;
		logic [OpW-1:0]   opcode;
	} item_t;

	typedef struct packed {
		logic            is_on;
		logic            changed;
		logic [DutyW-1:0] duty;
		logic [PctW-1:0]  level;
		logic [PctW-1:0]  set_point;
	} result_t;

	// floor(255*pct/100) through a reciprocal multiply; full level reads 254
	function automatic logic [DutyW-1:0] duty_of(input logic [PctW-1:0] pct);
		logic [14:0] scaled;
		logic [27:0] prod;
		scaled = {pct, 8'd0} - {8'd0, pct};
		prod = {13'd0, scaled} * 28'd5243;
		if (pct >= PCT_FULL) begin
			return 8'd254;
		end
		return prod[26:19];
	endfunction

	function automatic logic [PctW-1:0] ladder_next(input logic [PctW-1:0] sp);
		if (sp == 7'd2 || sp == 7'd5) return 7'd10;
		if (sp <= 7'd10) return 7'd15;
		if (sp <= 7'd15) return 7'd20;
		if (sp <= 7'd20) return 7'd25;
		if (sp <= 7'd25) return 7'd50;
		if (sp <= 7'd50) return 7'd75;
		if (sp <= 7'd75) return 7'd100;
		return 7'd10;
	endfunction

endpackage

/* sv/ldbr_in_stage.sv */
// Input register stage: captures one item per handshake and holds it until
// the control stage consumes it. Depends on ldbr_pkg.
module ldbr_in_stage
	import ldbr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* sv/ldbr_ctrl.sv */
// Dimmer state (set point, remembered level, output level, ramp direction)
// and the per-item update logic. Depends on ldbr_pkg.
module ldbr_ctrl
	import ldbr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  item_t           item_s1,
	input  logic [PctW-1:0] init_level,
	input  logic [7:0]      hold_thresh,
	output result_t         result
);

	logic [PctW-1:0] target_q, saved_q, out_pct_q;
	logic            falling_q;
	logic [PctW-1:0] target_d, saved_d, out_pct_d;
	logic            falling_d;
	logic            changed;
	logic            on;
	logic [PctW-1:0] init_sat;

	assign on = target_q != '0;
	assign init_sat = (init_level > PCT_FULL) ? PCT_FULL : init_level;

	always_comb begin
		target_d  = target_q;
		saved_d   = saved_q;
		out_pct_d = out_pct_q;
		falling_d = falling_q;
		changed   = 1'b0;
		case (item_s1.opcode)
			OP_TICK: begin
				if (target_q != out_pct_q) begin
					changed = 1'b1;
					if (target_q > out_pct_q) begin
						out_pct_d = out_pct_q + 7'd1;
					end else begin
						out_pct_d = out_pct_q - 7'd1;
					end
				end
			end
			OP_CLICK: begin
				if (on) begin
					saved_d  = target_q;
					target_d = '0;
				end else begin
					// off with nothing remembered: come up at the initial level
					target_d = (saved_q == target_q) ? init_sat : saved_q;
					saved_d  = '0;
				end
			end
			OP_DOUBLE: begin
				if (on) begin
					target_d = (target_q == 7'd2) ? 7'd5 : 7'd2;
				end
			end
			OP_TRIPLE: begin
				if (on) begin
					target_d = ladder_next(target_q);
				end
			end
			OP_LONG: begin
				if (on && item_s1.hold_time > {8'd0, hold_thresh}) begin
					if (!falling_q) begin
						if (target_q >= PCT_FULL) begin
							target_d  = PCT_FULL;
							falling_d = 1'b1;
						end else begin
							target_d = target_q + 7'd1;
						end
					end else begin
						if (target_q <= 7'd1) begin
							target_d  = 7'd1;
							falling_d = 1'b0;
						end else begin
							target_d = target_q - 7'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			saved_q   <= '0;
			out_pct_q <= '0;
			falling_q <= 1'b0;
		end else if (advance) begin
			target_q  <= target_d;
			saved_q   <= saved_d;
			out_pct_q <= out_pct_d;
			falling_q <= falling_d;
		end
	end

	assign result.set_point = target_d;
	assign result.level     = out_pct_d;
	assign result.duty      = duty_of(out_pct_d);
	assign result.changed   = changed;
	assign result.is_on     = target_d != '0;

`ifndef SYNTHESIS
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		target_q <= PCT_FULL)
		else $error("set point above full scale");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_pct_q <= PCT_FULL)
		else $error("output level above full scale");

	a_level_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.opcode != OP_TICK |=> $stable(out_pct_q))
		else $error("output level moved on a button item");

	a_changed_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && changed |=> out_pct_q != $past(out_pct_q))
		else $error("changed flagged without a level step");
`endif

endmodule

/* sv/led_dimmer_button_ramp.sv */
// LED dimmer button ramp top level: input stage, control stage, result
// register and configuration registers. Depends on ldbr_pkg, ldbr_in_stage,
// ldbr_ctrl.
//
// Usage: each item on s_axis is a button event or an output tick; every item
// yields exactly one result item on m_axis with the new set point, the output
// level, its duty and flags. cfg_* writes initial_level (index 0) and
// hold_threshold (index 1); cfg_ready is always high, other indexes are dropped.
// Write configuration only while no item is in flight.
// Path: an accepted item waits in the input register, then the state update
// and the result register take it when advance is high.
// Throughput: one item per cycle while m_axis_tready is high; the only loop
// is the state update in the control stage.
// Reset: set point, remembered level and output level go to 0, ramp direction
// to rising, initial_level to 50, hold_threshold to 10; both channels empty.
// Stall: with m_axis_tready low the result holds, one more item waits in the
// input register, and s_axis_tready then drops until the result is taken.
module led_dimmer_button_ramp
	import ldbr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // opcode[2:0], hold_time[18:3], zero pad
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,  // set_point[6:0], level[13:7], duty[21:14],
	                                           // changed[22], is_on[23]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	item_t           in_item;
	item_t           item_s1;
	logic            valid_s1;
	logic            advance;
	result_t         result;
	result_t         result_q;
	logic            out_valid_q;
	logic [PctW-1:0] init_level_q;
	logic [7:0]      hold_thresh_q;

	assign in_item.opcode    = s_axis_tdata[2:0];
	assign in_item.hold_time = s_axis_tdata[18:3];

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	ldbr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ldbr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item_s1     (item_s1),
		.init_level  (init_level_q),
		.hold_thresh (hold_thresh_q),
		.result      (result)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_level_q  <= 7'd50;
			hold_thresh_q <= 8'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INITIAL_LEVEL:  init_level_q  <= cfg_data[PctW-1:0];
				REG_HOLD_THRESHOLD: hold_thresh_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// result register: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {result_q.is_on, result_q.changed, result_q.duty,
	                        result_q.level, result_q.set_point};

endmodule

/* tb/ldbr_checker.sv */
// Checker for the LED dimmer: tracks set point, remembered level, output level and ramp
// direction from the accepted items and config writes, and compares every result item.
// Depends on ldbr_pkg for the item, result and register codes.
`timescale 1ns / 100ps
module ldbr_checker
	import ldbr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // opcode[2:0], hold_time[18:3], zero pad
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [23:0]         m_axis_tdata,  // set_point[6:0], level[13:7], duty[21:14],
	                                           // changed[22], is_on[23]
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  fail_count,
	output int                  pending
);

	// triple-click ladder, lowest rung in the lowest slot
	localparam logic [6:0][PctW-1:0] LADDER = {7'd100, 7'd75, 7'd50, 7'd25, 7'd20, 7'd15, 7'd10};

	logic [PctW-1:0] sp_now;
	logic [PctW-1:0] sp_saved;
	logic [PctW-1:0] lvl_now;
	logic            ramp_down;
	logic [PctW-1:0] init_level;
	logic [7:0]      hold_limit;
	int              errors;
	result_t         dimmer_q[$];

	function automatic logic [DutyW-1:0] duty_for(input logic [PctW-1:0] pct);
		if (pct >= PCT_FULL) return 8'd254;
		return DutyW'((32'd255 * pct) / 32'd100);
	endfunction

	// advance the lamp state by one item and return the result it must produce
	function automatic result_t predict_dimmer(input item_t it);
		result_t r;
		logic    lit;
		logic    found;
		lit = (sp_now != '0);
		r = '0;
		case (it.opcode)
			OP_TICK: if (sp_now != lvl_now) begin
				lvl_now = (sp_now > lvl_now) ? lvl_now + 1'b1 : lvl_now - 1'b1;
				r.changed = 1'b1;
			end
			OP_CLICK: begin
				if (sp_saved == sp_now) sp_saved = (init_level > PCT_FULL) ? PCT_FULL : init_level;
				if (lit) begin
					sp_saved = sp_now;
					sp_now = '0;
				end else begin
					sp_now = sp_saved;
					sp_saved = '0;
				end
			end
			OP_DOUBLE: if (lit) sp_now = (sp_now == 7'd2) ? 7'd5 : 7'd2;
			OP_TRIPLE: if (lit) begin
				if (sp_now == 7'd2 || sp_now == 7'd5) begin
					sp_now = LADDER[0];
				end else begin
					found = 1'b0;
					for (int i = 0; i < 6; i++) begin
						if (!found && sp_now <= LADDER[i]) begin
							sp_now = LADDER[i+1];
							found = 1'b1;
						end
					end
					if (!found) sp_now = LADDER[0];
				end
			end
			OP_LONG: if (lit && it.hold_time > hold_limit) begin
				if (!ramp_down) begin
					if (sp_now >= PCT_FULL) begin
						sp_now = PCT_FULL;
						ramp_down = 1'b1;
					end else begin
						sp_now = sp_now + 1'b1;
					end
				end else if (sp_now <= 7'd1) begin
					sp_now = 7'd1;
					ramp_down = 1'b0;
				end else begin
					sp_now = sp_now - 1'b1;
				end
			end
			default: ;
		endcase
		r.set_point = sp_now;
		r.level = lvl_now;
		r.duty = duty_for(lvl_now);
		r.is_on = (sp_now != '0);
		return r;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			sp_now = '0;
			sp_saved = '0;
			lvl_now = '0;
			ramp_down = 1'b0;
			init_level = 7'd50;
			hold_limit = 8'd10;
			errors = 0;
			dimmer_q.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata);
				if (dimmer_q.size() == 0) begin
					$display("%0t: unexpected result item %h", $time, m_axis_tdata);
					errors++;
				end else begin
					want = dimmer_q.pop_front();
					compare_field("set_point", want.set_point, got.set_point);
					compare_field("level", want.level, got.level);
					compare_field("duty", want.duty, got.duty);
					compare_field("changed", want.changed, got.changed);
					compare_field("is_on", want.is_on, got.is_on);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INITIAL_LEVEL:  init_level = cfg_data[PctW-1:0];
					REG_HOLD_THRESHOLD: hold_limit = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				dimmer_q.push_back(predict_dimmer(item_t'(s_axis_tdata[$bits(item_t)-1:0])));
			pending <= dimmer_q.size();
			fail_count <= errors;
		end
	end

endmodule

/* tb/led_dimmer_button_ramp_tb.sv */
// Testbench top for the LED dimmer: clock, reset, button and tick stimulus, config phases.
// Depends on ldbr_pkg, led_dimmer_button_ramp and ldbr_checker.
`timescale 1ns / 100ps
module led_dimmer_button_ramp_tb;
	import ldbr_pkg::*;

	localparam int IDLE_PCT = 17;
	localparam int STALL_LIMIT = 2000;
	localparam logic [OpW-1:0] OP_LAST = '1;
	localparam logic [CfgIdxW-1:0] REG_SPARE = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [23:0]         s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [23:0]         m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                no_idle = 1'b0;
	logic [7:0]          cur_thr = 8'd10;
	int                  fail_count;
	int                  pending;
	int                  quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	led_dimmer_button_ramp u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ldbr_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// end the run if nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d results outstanding",
			         $time, quiet_cycles, pending);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// leave tvalid high on return so back-to-back items need no extra edge
	task automatic send_item(input logic [OpW-1:0] op, input logic [HoldW-1:0] hold);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(24 - $bits(item_t)){1'b0}}, hold, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// hold the sender until every result item has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(input logic [7:0] lvl, input logic [7:0] thr, input bit spare);
		write_reg(REG_INITIAL_LEVEL, lvl);
		write_reg(REG_HOLD_THRESHOLD, thr);
		if (spare) write_reg(REG_SPARE, CfgDataW'($urandom()));
		cfg_valid <= 1'b0;
		cur_thr = thr;
	endtask

	task automatic run_random(input int count);
		int              sent;
		int              k;
		int              len;
		logic [OpW-1:0]  op;
		logic [HoldW-1:0] hold;
		sent = 0;
		while (sent < count) begin
			k = $urandom_range(0, 99);
			if (k < 4) begin
				// long ramp run: 30 to 110 presses, most held past the threshold, so the ramp can reach an end and turn around
				len = $urandom_range(30, 110);
				repeat (len) send_item(OP_LONG, ($urandom_range(0, 7) == 0) ?
					HoldW'($urandom_range(0, cur_thr)) :
					HoldW'(cur_thr) + HoldW'($urandom_range(1, 65535 - cur_thr)));
				sent += len;
			end else if (k < 8) begin
				// tick run so the output level catches up with the set point
				len = $urandom_range(20, 100);
				repeat (len) send_item(OP_TICK, HoldW'($urandom()));
				sent += len;
			end else begin
				k = $urandom_range(0, 99);
				if (k < 30) op = OP_TICK;
				else if (k < 42) op = OP_CLICK;
				else if (k < 54) op = OP_DOUBLE;
				else if (k < 70) op = OP_TRIPLE;
				else if (k < 95) op = OP_LONG;
				else op = OpW'($urandom_range(OP_LONG + 1, OP_LAST));
				case ($urandom_range(0, 5))
					0: hold = '0;
					1: hold = '1;
					2: hold = HoldW'(cur_thr);
					3: hold = HoldW'(cur_thr) + 1'b1;
					4: hold = HoldW'($urandom_range(0, 300));
					default: hold = HoldW'($urandom());
				endcase
				send_item(op, hold);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset config, initial level 50 and threshold 10
		send_item(OP_TICK, '1);
		send_item(OP_DOUBLE, '0);
		send_item(OP_TRIPLE, '0);
		send_item(OP_LONG, '1);
		send_item(OP_CLICK, '0);
		send_item(OP_TICK, '0);
		send_item(OP_DOUBLE, '0);
		send_item(OP_DOUBLE, '0);
		repeat (7) send_item(OP_TRIPLE, '0);
		send_item(OP_LONG, HoldW'(cur_thr));
		send_item(OP_LONG, HoldW'(cur_thr) + 1'b1);
		send_item(OP_LONG, '1);
		send_item(OP_TRIPLE, '0);
		send_item(OP_DOUBLE, '0);
		repeat (3) send_item(OP_LONG, '1);
		send_item(OP_CLICK, '0);
		send_item(OP_LONG + 1'b1, '0);
		send_item(OP_LAST, '1);
		send_item(OP_CLICK, '0);
		drain();

		// initial level above full scale, zero threshold
		set_regs(8'hFF, 8'd0, 1'b1);
		run_random(100);
		drain();

		set_regs(8'd0, 8'hFF, 1'b0);
		run_random(60);
		drain();

		set_regs(CfgDataW'($urandom()), CfgDataW'($urandom()), 1'b0);
		run_random(100);
		drain();

		// long stretch with both sides always ready
		no_idle <= 1'b1;
		set_regs(8'd100, 8'd10, 1'b0);
		run_random(120);
		drain();
		no_idle <= 1'b0;

		set_regs(CfgDataW'($urandom_range(1, 100)), CfgDataW'($urandom()), 1'b1);
		run_random(120);
		drain();

		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
